@@ sv/fcb_pkg.sv @@
// Package for the four-coil current balance integrator.
// Holds types, register indexes, reset values and widths; no dependencies.
`default_nettype none

package fcb_pkg;

	localparam int Lanes = 4;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_TARGET  = 3'd0,
		REG_GAIN    = 3'd1,
		REG_FLOOR   = 3'd2,
		REG_CEILING = 3'd3,
		REG_CAP     = 3'd4,
		REG_ALPHA   = 3'd5,
		REG_SENS    = 3'd6,
		REG_OFFSET  = 3'd7
	} reg_index_t;

	// Reset values
	localparam logic [14:0] TARGET_RST  = 15'd5000;
	localparam logic [15:0] GAIN_RST    = 16'd5033;
	localparam logic [14:0] FLOOR_RST   = 15'd1280;
	localparam logic [14:0] CEILING_RST = 15'd25344;
	localparam logic [14:0] CAP_RST     = 15'd12000;
	localparam logic [15:0] ALPHA_RST   = 16'd1311;
	localparam logic [14:0] DUTY_START  = 15'd17920;
	localparam logic signed [20:0] BACKOFF_STEP = 21'sd1280;

	// Shared multiplier operand widths
	localparam int MulAW = 17;
	localparam int MulBW = 29;
	localparam int MulPW = MulAW + MulBW;

	// Sequencer state and work phase
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_WB,
		ST_OUT
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_EMA,
		PH_CUR,
		PH_INT
	} phase_t;

	// Control from sequencer to datapath
	typedef struct packed {
		logic       idle;
		logic       accept;
		logic       issue;
		logic       wb;
		phase_t     phase;
		logic [1:0] lane;
		logic       out_load;
	} fcb_ctrl_t;

endpackage

`default_nettype wire

@@ sv/fcb_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on fcb_pkg for operand widths.
`default_nettype none

module fcb_mul (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic signed [fcb_pkg::MulAW-1:0] a,
	input  wire logic signed [fcb_pkg::MulBW-1:0] b,
	output logic signed [fcb_pkg::MulPW-1:0]      prod_q
);
	import fcb_pkg::*;

	// One product per issue cycle
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

`default_nettype wire

@@ sv/fcb_seq.sv @@
// Sequencer: walks the filter lanes, then, for a control item, the current and duty steps per coil.
// Depends on fcb_pkg for state, phase and control struct types.
`default_nettype none

module fcb_seq (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        action_q,
	input  wire logic        out_busy,
	output fcb_pkg::fcb_ctrl_t ctrl
);
	import fcb_pkg::*;

	seq_state_t state_q, state_d;
	phase_t     phase_q, phase_d;
	logic [1:0] lane_q, lane_d;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_EMA;
			lane_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			lane_q  <= lane_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		lane_d  = lane_q;
		ctrl.idle     = 1'b0;
		ctrl.accept   = 1'b0;
		ctrl.issue    = 1'b0;
		ctrl.wb       = 1'b0;
		ctrl.phase    = phase_q;
		ctrl.lane     = lane_q;
		ctrl.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctrl.idle = 1'b1;
				if (in_valid) begin
					ctrl.accept = 1'b1;
					state_d = ST_MUL;
					phase_d = PH_EMA;
					lane_d  = 2'd0;
				end
			end
			ST_MUL: begin
				ctrl.issue = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				ctrl.wb = 1'b1;
				state_d = ST_MUL;
				case (phase_q)
					PH_EMA: begin
						if (lane_q == 2'd3) begin
							lane_d = 2'd0;
							if (action_q) begin
								phase_d = PH_CUR;
							end else begin
								state_d = ST_IDLE;
							end
						end else begin
							lane_d = lane_q + 2'd1;
						end
					end
					PH_CUR: begin
						phase_d = PH_INT;
					end
					PH_INT: begin
						if (lane_q == 2'd3) begin
							state_d = ST_OUT;
						end else begin
							phase_d = PH_CUR;
							lane_d  = lane_q + 2'd1;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_OUT: begin
				if (!out_busy) begin
					ctrl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/four_coil_current_balance_integrator.sv @@
// Four-coil current balance integrator: EMA filter per coil, then integral duty control.
// Each item runs its steps in turn on one shared 17x29 multiplier, each an issue state then
// a write-back state: 4 filter steps, then for a control item a current and a duty step per
// coil, then the output load into the output register (held while the last result is still
// untaken), which sets out_valid; a filter-only item gives no result. in_ready is low until
// an item is through; a finished result waits in the output register while the next item runs.
// Reset (arst_n, asynchronous): config to defaults, filter unseeded, duties at 70 percent.
// Depends on fcb_pkg, fcb_seq and fcb_mul.
`default_nettype none

module four_coil_current_balance_integrator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	// Input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [11:0] sample_a,
	input  wire logic [11:0] sample_b,
	input  wire logic [11:0] sample_c,
	input  wire logic [11:0] sample_d,
	// Output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [14:0]      duty_a,
	output logic [14:0]      duty_b,
	output logic [14:0]      duty_c,
	output logic [14:0]      duty_d,
	output logic signed [15:0] current_a,
	output logic signed [15:0] current_b,
	output logic signed [15:0] current_c,
	output logic signed [15:0] current_d,
	output logic [3:0]       overcurrent_mask
);
	import fcb_pkg::*;

	// Configuration registers
	logic [14:0] target_q, floor_q, ceiling_q, cap_q;
	logic [15:0] gain_q, alpha_q;
	logic [63:0] sens_q, offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= TARGET_RST;
			gain_q    <= GAIN_RST;
			floor_q   <= FLOOR_RST;
			ceiling_q <= CEILING_RST;
			cap_q     <= CAP_RST;
			alpha_q   <= ALPHA_RST;
			sens_q    <= 64'd0;
			offset_q  <= 64'd0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_TARGET:  target_q  <= cfg_data[14:0];
				REG_GAIN:    gain_q    <= cfg_data[15:0];
				REG_FLOOR:   floor_q   <= cfg_data[14:0];
				REG_CEILING: ceiling_q <= cfg_data[14:0];
				REG_CAP:     cap_q     <= cfg_data[14:0];
				REG_ALPHA:   alpha_q   <= cfg_data[15:0];
				REG_SENS:    sens_q    <= cfg_data;
				REG_OFFSET:  offset_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer
	fcb_ctrl_t ctrl;
	logic      action_q;
	logic      out_busy;

	assign out_busy = out_valid && !out_ready;
	assign in_ready = ctrl.idle;

	fcb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action_q (action_q),
		.out_busy (out_busy),
		.ctrl     (ctrl)
	);

	// Latched item
	logic [11:0] samp_q [Lanes];

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			action_q  <= action;
			samp_q[0] <= sample_a;
			samp_q[1] <= sample_b;
			samp_q[2] <= sample_c;
			samp_q[3] <= sample_d;
		end
	end

	// Per-coil state
	logic [27:0]        level_q [Lanes];
	logic [14:0]        duty_q  [Lanes];
	logic signed [15:0] cur_q   [Lanes];
	logic [3:0]         over_q;
	logic               seeded_q;
	logic signed [17:0] err_q;

	// Selected lane values
	logic [11:0]        samp_l;
	logic [27:0]        level_l;
	logic [14:0]        duty_l;
	logic [15:0]        sens_l;
	logic signed [15:0] off_l;

	assign samp_l  = samp_q[ctrl.lane];
	assign level_l = level_q[ctrl.lane];
	assign duty_l  = duty_q[ctrl.lane];
	assign sens_l  = sens_q[{ctrl.lane, 4'd0} +: 16];
	assign off_l   = $signed(offset_q[{ctrl.lane, 4'd0} +: 16]);

	// Operand select for the shared multiplier
	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	logic signed [MulPW-1:0] prod_q;
	logic signed [28:0]      ema_diff;
	logic signed [17:0]      lvl_rel;

	assign ema_diff = $signed({1'b0, samp_l, 16'd0}) - $signed({1'b0, level_l});
	assign lvl_rel  = $signed({2'b00, level_l[27:12]}) - $signed({{2{off_l[15]}}, off_l});

	always_comb begin
		case (ctrl.phase)
			PH_EMA: begin
				mul_a = $signed({1'b0, alpha_q});
				mul_b = ema_diff;
			end
			PH_CUR: begin
				mul_a = $signed({1'b0, sens_l});
				mul_b = MulBW'(lvl_rel);
			end
			PH_INT: begin
				mul_a = $signed({1'b0, gain_q});
				mul_b = MulBW'(err_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	fcb_mul u_mul (
		.clk    (clk),
		.en     (ctrl.issue),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// Write-back arithmetic
	logic signed [29:0] prod_sh16;
	logic signed [33:0] prod_sh12;
	logic signed [29:0] level_new;
	logic signed [15:0] cur_sat;
	logic               over;
	logic signed [20:0] duty_step;
	logic signed [20:0] duty_sum;
	logic [14:0]        duty_new;

	assign prod_sh16 = prod_q[MulPW-1:16];
	assign prod_sh12 = prod_q[MulPW-1:12];
	assign level_new = $signed({2'b00, level_l}) + prod_sh16;

	// Saturate current to 16 bits
	always_comb begin
		if ((&prod_sh12[33:15]) || !(|prod_sh12[33:15])) begin
			cur_sat = prod_sh12[15:0];
		end else if (prod_sh12[33]) begin
			cur_sat = 16'sh8000;
		end else begin
			cur_sat = 16'sh7FFF;
		end
	end

	assign over = cur_sat > $signed({1'b0, cap_q});

	// Duty step and clamp, floor wins when below
	assign duty_step = over_q[ctrl.lane] ? -BACKOFF_STEP : prod_sh16[20:0];
	assign duty_sum  = $signed({6'd0, duty_l}) + duty_step;

	always_comb begin
		if (duty_sum < $signed({6'd0, floor_q})) begin
			duty_new = floor_q;
		end else if (duty_sum > $signed({6'd0, ceiling_q})) begin
			duty_new = ceiling_q;
		end else begin
			duty_new = duty_sum[14:0];
		end
	end

	// Filter and duty state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			for (int i = 0; i < Lanes; i++) begin
				level_q[i] <= 28'd0;
				duty_q[i]  <= DUTY_START;
			end
		end else if (ctrl.wb) begin
			case (ctrl.phase)
				PH_EMA: begin
					if (seeded_q) begin
						level_q[ctrl.lane] <= level_new[27:0];
					end else begin
						level_q[ctrl.lane] <= {samp_l, 16'd0};
					end
					if (ctrl.lane == 2'd3) begin
						seeded_q <= 1'b1;
					end
				end
				PH_INT: begin
					duty_q[ctrl.lane] <= duty_new;
				end
				default: ;
			endcase
		end
	end

	// Current, overcurrent flag and error term
	always_ff @(posedge clk) begin
		if (ctrl.wb && ctrl.phase == PH_CUR) begin
			cur_q[ctrl.lane]  <= cur_sat;
			over_q[ctrl.lane] <= over;
			err_q <= $signed({3'b000, target_q}) - $signed({{2{cur_sat[15]}}, cur_sat});
		end
	end

	// Output register
	logic [14:0]        duty_o_q [Lanes];
	logic signed [15:0] cur_o_q  [Lanes];
	logic [3:0]         mask_o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			for (int i = 0; i < Lanes; i++) begin
				duty_o_q[i] <= duty_q[i];
				cur_o_q[i]  <= cur_q[i];
			end
			mask_o_q <= over_q;
		end
	end

	assign duty_a    = duty_o_q[0];
	assign duty_b    = duty_o_q[1];
	assign duty_c    = duty_o_q[2];
	assign duty_d    = duty_o_q[3];
	assign current_a = cur_o_q[0];
	assign current_b = cur_o_q[1];
	assign current_c = cur_o_q[2];
	assign current_d = cur_o_q[3];
	assign overcurrent_mask = mask_o_q;

	// Checks
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while item in progress");

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!out_valid || out_ready))
		else $error("result overwrote pending output");

	a_load_needs_action: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> action_q)
		else $error("result produced for filter-only item");

	a_seeded_after_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.wb && ctrl.phase == PH_EMA && ctrl.lane == 2'd3) |=> seeded_q)
		else $error("filter not marked seeded");

endmodule

`default_nettype wire

@@ tb/four_coil_current_balance_integrator_test.sv @@
// Testbench for four_coil_current_balance_integrator: random coil sample sets are sent through
// a valid/ready driver, and each duty update is checked against an in-bench model of the block.
// Depends on fcb_pkg and the four_coil_current_balance_integrator RTL.
`timescale 1ns / 100ps

module four_coil_current_balance_integrator_test;
	import fcb_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT   = 4000;
	localparam int LONG_HOLD     = 300;

	typedef struct packed {
		logic             act;
		logic [3:0][11:0] sample;
	} coil_set_t;

	typedef struct packed {
		logic [3:0][14:0] duty;
		logic [3:0][15:0] current;
		logic [3:0]       ovc;
	} duty_update_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = 1'b0;
	logic [11:0] sample_a = '0, sample_b = '0, sample_c = '0, sample_d = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [14:0] duty_a, duty_b, duty_c, duty_d;
	logic signed [15:0] current_a, current_b, current_c, current_d;
	logic [3:0]  overcurrent_mask;

	wire [3:0][14:0] duty_seen    = {duty_d, duty_c, duty_b, duty_a};
	wire [3:0][15:0] current_seen = {current_d, current_c, current_b, current_a};

	// Register copies kept by the bench
	logic [14:0] set_target  = TARGET_RST;
	logic [15:0] set_gain    = GAIN_RST;
	logic [14:0] set_floor   = FLOOR_RST;
	logic [14:0] set_ceiling = CEILING_RST;
	logic [14:0] set_cap     = CAP_RST;
	logic [15:0] set_alpha   = ALPHA_RST;
	logic [63:0] set_sens    = '0;
	logic [63:0] set_offset  = '0;

	// Filter and duty state of the bench model
	longint ema_q16 [Lanes] = '{default: 0};
	longint duty_q88 [Lanes] = '{default: longint'(DUTY_START)};
	bit     filter_primed = 1'b0;

	coil_set_t    coil_sets_to_send [$];
	duty_update_t predicted_updates [$];

	int mismatches = 0;
	int quiet_cycles = 0;
	int stall_asked = 0;
	int stall_taken = 0;
	int hold_left = 0;
	bit calm = 1'b0;

	four_coil_current_balance_integrator uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.sample_a(sample_a), .sample_b(sample_b), .sample_c(sample_c), .sample_d(sample_d),
		.out_valid(out_valid), .out_ready(out_ready),
		.duty_a(duty_a), .duty_b(duty_b), .duty_c(duty_c), .duty_d(duty_d),
		.current_a(current_a), .current_b(current_b),
		.current_c(current_c), .current_d(current_d),
		.overcurrent_mask(overcurrent_mask)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int lane, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s lane %0d: got 'h%h, expected 'h%h",
				name, lane, got, want));
	endtask

	// Filter every lane, then run the integral step when asked
	function automatic void advance_coils(input coil_set_t cs);
		longint diff, lvl16, sens, off, cur, d;
		duty_update_t upd;
		upd.ovc = '0;
		for (int i = 0; i < Lanes; i++) begin
			if (!filter_primed) begin
				ema_q16[i] = longint'(cs.sample[i]) <<< 16;
			end else begin
				diff = (longint'(cs.sample[i]) <<< 16) - ema_q16[i];
				ema_q16[i] += (longint'(set_alpha) * diff) >>> 16;
			end
		end
		filter_primed = 1'b1;
		if (!cs.act)
			return;
		for (int i = 0; i < Lanes; i++) begin
			sens = longint'(set_sens[16*i +: 16]);
			off = $signed(set_offset[16*i +: 16]);
			lvl16 = ema_q16[i] >>> 12;
			cur = (sens * (lvl16 - off)) >>> 12;
			if (cur > 32767)
				cur = 32767;
			else if (cur < -32768)
				cur = -32768;
			d = duty_q88[i];
			if (cur > longint'(set_cap)) begin
				d -= longint'(BACKOFF_STEP);
				upd.ovc[i] = 1'b1;
			end else begin
				d += (longint'(set_gain) * (longint'(set_target) - cur)) >>> 16;
			end
			// floor is checked first, so it wins when the duty is below it
			if (d < longint'(set_floor))
				d = longint'(set_floor);
			else if (d > longint'(set_ceiling))
				d = longint'(set_ceiling);
			duty_q88[i] = d;
			upd.duty[i] = d[14:0];
			upd.current[i] = cur[15:0];
		end
		predicted_updates.push_back(upd);
	endfunction

	task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_TARGET:  set_target = value[14:0];
			REG_GAIN:    set_gain = value[15:0];
			REG_FLOOR:   set_floor = value[14:0];
			REG_CEILING: set_ceiling = value[14:0];
			REG_CAP:     set_cap = value[14:0];
			REG_ALPHA:   set_alpha = value[15:0];
			REG_SENS:    set_sens = value;
			REG_OFFSET:  set_offset = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send(input logic act, input logic [11:0] a, b, c, d);
		coil_sets_to_send.push_back({act, d, c, b, a});
	endtask

	// Wait for every set to go out and every update to return, then let the block settle
	task automatic drain();
		while (coil_sets_to_send.size() != 0 || predicted_updates.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] with_junk(input logic [63:0] value, input int width);
		logic [63:0] junk;
		junk = {$urandom(), $urandom()};
		if ($urandom_range(1) == 0)
			return value;
		return (junk << width) | value;
	endfunction

	function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
		case ($urandom_range(4))
			0: return lo;
			1: return hi;
			default: return lo + $urandom_range(hi - lo);
		endcase
	endfunction

	// Driver: offer queued sample sets, hold each until its transfer
	always @(posedge clk) begin
		if (in_valid && in_ready)
			advance_coils(coil_sets_to_send.pop_front());
		if (in_valid && !in_ready) begin
			// hold payload
		end else if (coil_sets_to_send.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
			in_valid <= 1'b1;
			action <= coil_sets_to_send[0].act;
			sample_a <= coil_sets_to_send[0].sample[0];
			sample_b <= coil_sets_to_send[0].sample[1];
			sample_c <= coil_sets_to_send[0].sample[2];
			sample_d <= coil_sets_to_send[0].sample[3];
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Monitor: check each update transfer, drive out_ready with random and long stalls
	always @(posedge clk) begin
		duty_update_t want;
		if (out_valid && out_ready) begin
			if (predicted_updates.size() == 0) begin
				report_mismatch("update with none predicted");
			end else begin
				want = predicted_updates.pop_front();
				for (int i = 0; i < Lanes; i++) begin
					check_field("duty", i, {1'b0, duty_seen[i]}, {1'b0, want.duty[i]});
					check_field("current", i, current_seen[i], want.current[i]);
				end
				check_field("overcurrent", 0, {12'd0, overcurrent_mask}, {12'd0, want.ovc});
			end
		end
		if (stall_taken != stall_asked) begin
			stall_taken = stall_asked;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 7);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[four_coil_current_balance_integrator] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [63:0] lanes_s, lanes_o;
		logic [3:0][11:0] smp;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: first set seeds the filter and runs control at once
		send(1'b1, 12'd0, 12'd4095, 12'hAAA, 12'h555);
		send(1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		send(1'b1, 12'd0, 12'd0, 12'd0, 12'd0);
		send(1'b1, 12'd4095, 12'd0, 12'd4095, 12'd0);
		drain();

		// Realistic sensor scale, fast filter: idle, target, cap edge, full scale
		write_reg(REG_SENS, {4{16'd3907}});
		write_reg(REG_OFFSET, {4{16'hFD7A}});
		write_reg(REG_ALPHA, 64'd65535);
		send(1'b1, 12'd0, 12'd328, 12'd786, 12'd4095);
		send(1'b1, 12'd4095, 12'd786, 12'd328, 12'd0);
		send(1'b0, 12'd800, 12'd800, 12'd800, 12'd800);
		send(1'b1, 12'd786, 12'd787, 12'd785, 12'd900);
		send(1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		drain();

		// Positive saturation under a top cap; floor above ceiling
		write_reg(REG_SENS, {4{16'hFFFF}});
		write_reg(REG_OFFSET, {4{16'h8000}});
		write_reg(REG_CAP, 64'd32767);
		write_reg(REG_GAIN, 64'd65535);
		write_reg(REG_FLOOR, 64'd25600);
		write_reg(REG_CEILING, 64'd0);
		send(1'b1, 12'd4095, 12'd0, 12'd2048, 12'd1);
		send(1'b1, 12'd0, 12'd4095, 12'd1, 12'd2048);
		send(1'b1, 12'd100, 12'd200, 12'd300, 12'd400);
		drain();

		// Negative saturation, frozen filter, zero cap, top target
		write_reg(REG_OFFSET, {4{16'h7FFF}});
		write_reg(REG_ALPHA, 64'd0);
		write_reg(REG_CAP, 64'd0);
		write_reg(REG_TARGET, 64'd32767);
		write_reg(REG_FLOOR, 64'd0);
		write_reg(REG_CEILING, 64'd25600);
		send(1'b1, 12'd4095, 12'd4095, 12'd0, 12'd0);
		send(1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
		send(1'b1, 12'd1, 12'd2, 12'd3, 12'd4);
		drain();
		write_reg(REG_TARGET, 64'd0);
		send(1'b1, 12'd0, 12'd4095, 12'd0, 12'd4095);
		send(1'b1, 12'd2000, 12'd1000, 12'd500, 12'd250);
		drain();

		// Random phases: new settings each time, then a burst of sample sets
		for (int phase = 0; phase < 8; phase++) begin
			for (int i = 0; i < Lanes; i++) begin
				case ($urandom_range(3))
					0: lanes_s[16*i +: 16] = 16'd0;
					1: lanes_s[16*i +: 16] = 16'hFFFF;
					default: lanes_s[16*i +: 16] = 16'(2500 + $urandom_range(3000));
				endcase
				if ($urandom_range(3) == 0)
					lanes_o[16*i +: 16] = 16'($urandom_range(65535));
				else
					lanes_o[16*i +: 16] = 16'($urandom_range(2000)) - 16'd1000;
			end
			write_reg(REG_TARGET, with_junk(64'(pick(0, 32767)), 15));
			write_reg(REG_GAIN, with_junk(64'(pick(0, 65535)), 16));
			write_reg(REG_FLOOR, with_junk(64'(pick(0, 25600)), 15));
			write_reg(REG_CEILING, with_junk(64'(pick(0, 25600)), 15));
			write_reg(REG_CAP, with_junk(64'(pick(0, 32767)), 15));
			write_reg(REG_ALPHA, with_junk(64'(pick(0, 65535)), 16));
			write_reg(REG_SENS, lanes_s);
			write_reg(REG_OFFSET, lanes_o);
			calm = (phase == 3);
			for (int k = 0; k < 50; k++) begin
				for (int i = 0; i < Lanes; i++) begin
					case ($urandom_range(9))
						0: smp[i] = 12'd0;
						1: smp[i] = 12'd4095;
						2, 3, 4, 5, 6: smp[i] = 12'($urandom_range(1200));
						default: smp[i] = 12'($urandom_range(4095));
					endcase
				end
				send($urandom_range(99) < 65, smp[0], smp[1], smp[2], smp[3]);
			end
			// long receiver hold-off while sets keep coming
			if (phase == 5)
				stall_asked++;
			drain();
		end
		calm = 1'b0;

		if (mismatches == 0)
			$display("[four_coil_current_balance_integrator] OK");
		else
			$display("[four_coil_current_balance_integrator] ERROR");
		$finish;
	end

endmodule
